/* hdl/senc_pkg.sv */
// Shared constants and types for the second-extreme neighbour clamp.
package senc_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int COL_BITS    = $clog2(MAX_COLS);
    localparam int CFG_BITS    = 11;
    localparam int LINE_BITS   = 2 * SAMPLE_BITS;

    // Register indexes of the configuration port
    localparam logic REG_LINE_WIDTH = 1'b0;
    localparam logic REG_LINE_COUNT = 1'b1;

    localparam logic [CFG_BITS-1:0] LINE_WIDTH_RESET = CFG_BITS'(512);
    localparam logic [CFG_BITS-1:0] LINE_COUNT_RESET = CFG_BITS'(512);
    localparam logic [CFG_BITS-1:0] DIM_MIN          = CFG_BITS'(3);
    localparam logic [CFG_BITS-1:0] DIM_MAX          = CFG_BITS'(1024);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // 3x3 window around the centre pixel
    typedef struct packed {
        t_sample tl;
        t_sample tc;
        t_sample tr;
        t_sample ml;
        t_sample mc;
        t_sample mr;
        t_sample bl;
        t_sample bc;
        t_sample br;
    } t_window;

endpackage

/* hdl/senc_ram.sv */
// Generic simple dual-port RAM with registered read.
module senc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/senc_filter.sv */
// Second-extreme search over the eight neighbours and clamp of the centre.
module senc_filter (
    input  senc_pkg::t_window i_win,
    output senc_pkg::t_sample o_value
);
    import senc_pkg::*;

    t_sample nb [8];
    t_sample first;
    t_sample second;
    t_sample centre;

    always_comb begin
        nb[0] = i_win.tl;
        nb[1] = i_win.tc;
        nb[2] = i_win.tr;
        nb[3] = i_win.ml;
        nb[4] = i_win.mr;
        nb[5] = i_win.bl;
        nb[6] = i_win.bc;
        nb[7] = i_win.br;
        centre = i_win.mc;
        first  = '0;
        second = '0;
        o_value = '0;
        if (centre > 0) begin
            // Seed with the top pair, then fold in positive neighbours
            if (nb[0] > nb[1]) begin
                first  = nb[0];
                second = nb[1];
            end else begin
                first  = nb[1];
                second = nb[0];
            end
            for (int i = 2; i < 8; i++) begin
                if (nb[i] > 0) begin
                    if (nb[i] > first) begin
                        second = first;
                        first  = nb[i];
                    end else if (nb[i] > second) begin
                        second = nb[i];
                    end
                end
            end
            if (second <= 0) begin
                o_value = '0;
            end else begin
                o_value = (centre < second) ? centre : second;
            end
        end else if (centre < 0) begin
            // Mirror case: two smallest, negative neighbours only
            if (nb[0] > nb[1]) begin
                first  = nb[1];
                second = nb[0];
            end else begin
                first  = nb[0];
                second = nb[1];
            end
            for (int i = 2; i < 8; i++) begin
                if (nb[i] < 0) begin
                    if (nb[i] < first) begin
                        second = first;
                        first  = nb[i];
                    end else if (nb[i] < second) begin
                        second = nb[i];
                    end
                end
            end
            if (second >= 0) begin
                o_value = '0;
            end else begin
                o_value = (centre > second) ? centre : second;
            end
        end
    end

endmodule

/* hdl/second_extreme_neighbour_clamp.sv */
// Top level of the second-extreme neighbour clamp over a raster pixel stream.
//
// Takes one signed difference pixel per clock in raster order while o_stall
// is low, and emits one clamped value per interior centre pixel; border
// pixels give no request. A pixel taken is registered in stage 1 while the
// line buffer RAM, with its registered read, delivers the neighbours from the
// two previous lines; the compare network then fills the output register when
// stage 1 advances, which an output stall can hold back. Sustained rate is one
// pixel per clock when the output is not stalled. The line buffers need no
// clearing after reset; line_width and line_count are used clamped to 3..1024
// and are to be written only while the block is idle.
module second_extreme_neighbour_clamp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [senc_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [senc_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                              i_frame_start,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [senc_pkg::COL_BITS-1:0]     o_row,
    output logic [senc_pkg::COL_BITS-1:0]     o_column,
    output logic signed [senc_pkg::SAMPLE_BITS-1:0] o_value
);
    import senc_pkg::*;

    logic [CFG_BITS-1:0] r_line_width;
    logic [CFG_BITS-1:0] r_line_count;
    logic [CFG_BITS-1:0] w_eff;
    logic [CFG_BITS-1:0] h_eff;

    logic [COL_BITS-1:0] r_row;
    logic [COL_BITS-1:0] r_col;
    logic [COL_BITS-1:0] row_now;
    logic [COL_BITS-1:0] col_now;
    logic [COL_BITS-1:0] n_row;
    logic [COL_BITS-1:0] n_col;
    logic [CFG_BITS-1:0] row_inc;
    logic [CFG_BITS-1:0] col_inc;
    logic                emit_now;

    // Stage 1 request
    logic                r_p1_valid;
    logic                r_p1_emit;
    t_sample             r_p1_x;
    logic [COL_BITS-1:0] r_p1_row;
    logic [COL_BITS-1:0] r_p1_col;
    logic                r_fwd;
    logic [LINE_BITS-1:0] r_fwd_data;

    t_sample             r_win [6];
    logic [LINE_BITS-1:0] ram_rdata;
    logic [LINE_BITS-1:0] line_data;
    logic [LINE_BITS-1:0] wr_data;
    t_sample             top_now;
    t_sample             mid_now;
    t_window             win;
    t_sample             filt_value;

    logic                accept;
    logic                out_free;
    logic                advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
            r_line_count <= LINE_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LINE_WIDTH: r_line_width <= i_cfg_data;
                REG_LINE_COUNT: r_line_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff = (r_line_width < DIM_MIN) ? DIM_MIN :
                   (r_line_width > DIM_MAX) ? DIM_MAX : r_line_width;
    assign h_eff = (r_line_count < DIM_MIN) ? DIM_MIN :
                   (r_line_count > DIM_MAX) ? DIM_MAX : r_line_count;

    // Handshake: stage 1 drains when it has no result or the output is free
    assign out_free = !o_valid || !i_stall;
    assign advance  = r_p1_valid && (!r_p1_emit || out_free);
    assign o_stall  = r_p1_valid && !advance;
    assign accept   = i_valid && !o_stall;

    // Position of the incoming pixel and the next counts
    always_comb begin
        row_now = i_frame_start ? '0 : r_row;
        col_now = i_frame_start ? '0 : r_col;
        row_inc = {1'b0, row_now} + CFG_BITS'(1);
        col_inc = {1'b0, col_now} + CFG_BITS'(1);
        emit_now = (row_now >= COL_BITS'(2)) && (row_inc <= h_eff) &&
                   (col_now >= COL_BITS'(2)) && (col_inc <= w_eff);
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc[COL_BITS-1:0];
        end else begin
            n_col = col_inc[COL_BITS-1:0];
            n_row = row_now;
        end
    end

    // Advance counts and load stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_p1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
                r_fwd <= advance && (r_p1_col == col_now);
            end
            if (accept) begin
                r_p1_valid <= 1'b1;
            end else if (advance) begin
                r_p1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p1_emit  <= emit_now;
            r_p1_x     <= i_sample;
            r_p1_row   <= row_now;
            r_p1_col   <= col_now;
            r_fwd_data <= wr_data;
        end
    end

    // Both line stores share one address, older line in the upper half
    senc_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (advance),
        .i_waddr (r_p1_col),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (col_now),
        .o_rdata (ram_rdata)
    );

    // Bypass a write to the address read in the same cycle
    assign line_data = r_fwd ? r_fwd_data : ram_rdata;
    assign top_now   = line_data[LINE_BITS-1:SAMPLE_BITS];
    assign mid_now   = line_data[SAMPLE_BITS-1:0];
    assign wr_data   = {mid_now, r_p1_x};

    // Assemble the 3x3 window
    always_comb begin
        win.tl = r_win[0];
        win.tc = r_win[1];
        win.tr = top_now;
        win.ml = r_win[2];
        win.mc = r_win[3];
        win.mr = mid_now;
        win.bl = r_win[4];
        win.bc = r_win[5];
        win.br = r_p1_x;
    end

    senc_filter u_filter (
        .i_win   (win),
        .o_value (filt_value)
    );

    // Shift the window columns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (advance) begin
            r_win[0] <= r_win[1];
            r_win[1] <= top_now;
            r_win[2] <= r_win[3];
            r_win[3] <= mid_now;
            r_win[4] <= r_win[5];
            r_win[5] <= r_p1_x;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (advance && r_p1_emit) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_p1_emit) begin
            o_row    <= r_p1_row - COL_BITS'(1);
            o_column <= r_p1_col - COL_BITS'(1);
            o_value  <= filt_value;
        end
    end

endmodule
